// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define A2B_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("a2b: assertion failed");

// next-cycle implication
`define A2B_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("a2b: assertion failed");

`endif

// ----- rtl/a2b_pkg.sv -----
// ----------------------------------------------------------------------------
// a2b_pkg
// Types and constants shared by the length-prefix to start-code converter.
// ----------------------------------------------------------------------------
package a2b_pkg;

	typedef enum logic [1:0] {
		PH_PREFIX  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_DRAIN   = 2'd2
	} a2b_phase_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_TRUNC = 2'd1,
		ST_ZERO  = 2'd2,
		ST_PAST  = 2'd3
	} a2b_status_t;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_BYTES = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_SC      = 1'b1;

	localparam logic [2:0] LB_MIN       = 3'd1;
	localparam logic [2:0] LB_MAX       = 3'd4;
	localparam logic [2:0] SC_LONG_LEN  = 3'd4;
	localparam logic [2:0] SC_SHORT_LEN = 3'd3;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;

	// one accepted byte's worth of output work
	typedef struct packed {
		logic [7:0]  data;
		logic        emit_start;
		logic        long_sc;
		logic        emit_data;
		logic        emit_status;
		a2b_status_t status;
	} a2b_cmd_t;

endpackage

// ----- rtl/a2b_if.sv -----
// ----------------------------------------------------------------------------
// a2b channel interfaces
// Valid/ready channels for input bytes and output results.
// ----------------------------------------------------------------------------
interface a2b_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       frame_end;

	modport source (output valid, output in_byte, output frame_end, input ready);
	modport sink   (input valid, input in_byte, input frame_end, output ready);
endinterface

interface a2b_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       is_status;
	logic [1:0] frame_status;
	logic       run_last;

	modport source (output valid, output out_byte, output is_status,
		output frame_status, output run_last, input ready);
	modport sink   (input valid, input out_byte, input is_status,
		input frame_status, input run_last, output ready);
endinterface

// ----- rtl/a2b_front.sv -----
// ----------------------------------------------------------------------------
// a2b_front
// Accepts frame bytes, parses length prefixes and tracks payload, issuing
// one output command per byte that produces results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module a2b_front import a2b_pkg::*; #(
	parameter int LENGTH_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	a2b_in_if.sink                in_ch,
	input  logic                  q_full,
	output logic                  push,
	output a2b_cmd_t              push_cmd
);

	logic [2:0]             lb_q;
	logic                   long_sc_q;
	logic [2:0]             lb_eff;

	a2b_phase_t             phase_q, phase_d;
	logic [LENGTH_BITS-1:0] accum_q, accum_d;
	logic [2:0]             pcount_q, pcount_d;
	logic [LENGTH_BITS-1:0] left_q, left_d;
	logic                   start_q, start_d;
	a2b_status_t            err_q, err_d, err_new;

	logic [LENGTH_BITS+7:0] wide;
	logic [LENGTH_BITS-1:0] accum_shift;
	logic [LENGTH_BITS-1:0] left_dec;
	logic [2:0]             pcount_inc;
	logic                   accept;
	logic                   last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lb_q      <= LB_MAX;
			long_sc_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LENGTH_BYTES: lb_q      <= cfg_data;
				CFG_LONG_SC:      long_sc_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (lb_q < LB_MIN)
			lb_eff = LB_MIN;
		else if (lb_q > LB_MAX)
			lb_eff = LB_MAX;
		else
			lb_eff = lb_q;
	end

	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && in_ch.ready;
	assign last        = in_ch.frame_end;

	assign wide        = {accum_q, in_ch.in_byte};
	assign accum_shift = wide[LENGTH_BITS-1:0];
	assign left_dec    = left_q - LENGTH_BITS'(1);
	assign pcount_inc  = pcount_q + 3'd1;

	// next state
	always_comb begin
		phase_d  = phase_q;
		accum_d  = accum_q;
		pcount_d = pcount_q;
		left_d   = left_q;
		start_d  = start_q;
		err_new  = err_q;
		unique case (phase_q)
			PH_PREFIX: begin
				accum_d  = accum_shift;
				pcount_d = pcount_inc;
				if (pcount_inc >= lb_eff) begin
					if (accum_shift == '0) begin
						err_new = ST_ZERO;
						phase_d = PH_DRAIN;
					end else if (last) begin
						err_new = ST_PAST;
						phase_d = PH_DRAIN;
					end else begin
						left_d  = accum_shift;
						start_d = 1'b1;
						phase_d = PH_PAYLOAD;
					end
					accum_d  = '0;
					pcount_d = '0;
				end else if (last) begin
					err_new = ST_TRUNC;
					phase_d = PH_DRAIN;
				end
			end
			PH_PAYLOAD: begin
				start_d = 1'b0;
				left_d  = left_dec;
				if (left_dec == '0) begin
					phase_d = PH_PREFIX;
				end else if (last) begin
					err_new = ST_PAST;
					phase_d = PH_DRAIN;
				end
			end
			default: ;
		endcase
		err_d = err_new;
		if (last) begin
			phase_d  = PH_PREFIX;
			accum_d  = '0;
			pcount_d = '0;
			left_d   = '0;
			start_d  = 1'b0;
			err_d    = ST_OK;
		end
	end

	// command out
	always_comb begin
		push_cmd.data        = in_ch.in_byte;
		push_cmd.emit_start  = (phase_q == PH_PAYLOAD) && start_q;
		push_cmd.long_sc     = long_sc_q;
		push_cmd.emit_data   = (phase_q == PH_PAYLOAD);
		push_cmd.emit_status = last;
		push_cmd.status      = last ? err_new : ST_OK;
		push = accept && (push_cmd.emit_data || last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_PREFIX;
			accum_q  <= '0;
			pcount_q <= '0;
			left_q   <= '0;
			start_q  <= 1'b0;
			err_q    <= ST_OK;
		end else if (accept) begin
			phase_q  <= phase_d;
			accum_q  <= accum_d;
			pcount_q <= pcount_d;
			left_q   <= left_d;
			start_q  <= start_d;
			err_q    <= err_d;
		end
	end

	`A2B_ASSERT_IMP(a_payload_owed, phase_q == PH_PAYLOAD, left_q != '0)
	`A2B_ASSERT_NXT(a_frame_clears, accept && last,
		phase_q == PH_PREFIX && pcount_q == '0 && err_q == ST_OK && !start_q)

endmodule

// ----- rtl/a2b_cmdq.sv -----
// ----------------------------------------------------------------------------
// a2b_cmdq
// Short command queue between the parser and the output sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module a2b_cmdq import a2b_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  a2b_cmd_t push_cmd,
	output logic     full,
	input  logic     pop,
	output logic     head_valid,
	output a2b_cmd_t head_cmd
);

	a2b_cmd_t        mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_AW:0]   count_q;

	assign full       = (count_q == (Q_AW+1)'(Q_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + Q_AW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			if (push && !pop)
				count_q <= count_q + (Q_AW+1)'(1);
			else if (pop && !push)
				count_q <= count_q - (Q_AW+1)'(1);
		end
	end

	`A2B_ASSERT_NXT(a_count_up, push && !pop, count_q == $past(count_q) + (Q_AW+1)'(1))

endmodule

// ----- rtl/a2b_back.sv -----
// ----------------------------------------------------------------------------
// a2b_back
// Expands queued commands into start code, payload and status beats.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module a2b_back import a2b_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     head_valid,
	input  a2b_cmd_t head_cmd,
	output logic     pop,
	a2b_out_if.source out_ch
);

	logic [2:0]  pos_q;
	logic [2:0]  n_sc;
	logic [2:0]  total;
	logic        load;
	logic        res_last;
	logic [7:0]  res_byte;
	logic        res_status;
	a2b_status_t res_fs;

	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        is_status_q;
	a2b_status_t fs_q;
	logic        run_last_q;

	always_comb begin
		if (!head_cmd.emit_start)
			n_sc = 3'd0;
		else if (head_cmd.long_sc)
			n_sc = SC_LONG_LEN;
		else
			n_sc = SC_SHORT_LEN;
		total = n_sc + {2'b00, head_cmd.emit_data} + {2'b00, head_cmd.emit_status};

		res_byte   = 8'd0;
		res_status = 1'b0;
		res_fs     = ST_OK;
		if (pos_q < n_sc) begin
			res_byte = (pos_q == n_sc - 3'd1) ? 8'd1 : 8'd0;
		end else if (pos_q == n_sc && head_cmd.emit_data) begin
			res_byte = head_cmd.data;
		end else begin
			res_status = 1'b1;
			res_fs     = head_cmd.status;
		end
		res_last = (pos_q == total - 3'd1);
	end

	assign load = head_valid && (!out_valid_q || out_ch.ready);
	assign pop  = load && res_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				pos_q <= res_last ? 3'd0 : pos_q + 3'd1;
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q  <= res_byte;
			is_status_q <= res_status;
			fs_q        <= res_fs;
			run_last_q  <= res_last;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.out_byte     = out_byte_q;
	assign out_ch.is_status    = is_status_q;
	assign out_ch.frame_status = fs_q;
	assign out_ch.run_last     = run_last_q;

	`A2B_ASSERT_IMP(a_pos_in_range, head_valid, pos_q < total)
	`A2B_ASSERT_IMP(a_status_closes, out_valid_q && is_status_q, run_last_q)

endmodule

// ----- rtl/avcc_to_annexb_converter.sv -----
// ----------------------------------------------------------------------------
// avcc_to_annexb_converter
// Length-prefixed NAL unit stream to start-code stream converter.
// ----------------------------------------------------------------------------
// Usage: frame bytes enter on in_ch, one beat per byte, frame_end high on the
// final byte. Results leave on out_ch: start code bytes, payload bytes and one
// status beat per frame (is_status high, frame_status 0 ok, 1 truncated prefix,
// 2 zero length, 3 length past end). run_last marks the final beat caused by
// an input byte. Bytes of a bad frame already sent stand; discard on status.
// cfg_index 0 sets the prefix length (1..4 bytes), 1 selects the 4-byte start
// code. Write configuration only between frames with the block empty.
// An accepted byte's results pass through the command queue and the output
// register. Throughput: one byte per cycle while the queue is not full; a
// unit's first payload byte yields the start code and the byte, the frame_end
// byte one more beat for status. Prefix and dropped bytes produce no output.
// A four-entry command queue separates parsing from output sequencing; when
// out_ch stalls the queue fills and in_ch.ready falls once it is full.
// Reset clears parser state and queue and restores the configuration defaults.
// ----------------------------------------------------------------------------
module avcc_to_annexb_converter import a2b_pkg::*; #(
	parameter int LENGTH_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	a2b_in_if.sink                in_ch,
	a2b_out_if.source             out_ch
);

	logic     push;
	a2b_cmd_t push_cmd;
	logic     q_full;
	logic     pop;
	logic     head_valid;
	a2b_cmd_t head_cmd;

	a2b_front #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.q_full    (q_full),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	a2b_cmdq u_cmdq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	a2b_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.out_ch     (out_ch)
	);

endmodule

// ----- tb/tb_avcc_to_annexb_converter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_avcc_to_annexb_converter
// Drives length-prefixed frames into the converter and checks every output
// beat against an in-bench model of the start-code conversion: start code
// insertion, payload pass-through and the end-of-frame status for good,
// truncated, zero-length and overrunning units, under several prefix lengths
// and both start code forms, with random input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_avcc_to_annexb_converter;
	import a2b_pkg::*;

	localparam int LEN_W        = 32;
	localparam int ITEMS_TARGET = 270;
	localparam int IDLE_LIMIT   = 2000;
	localparam int SETTLE       = 8;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        is_status;
		a2b_status_t status;
		logic        run_last;
	} conv_beat_t;

	typedef enum {FL_NONE, FL_TRUNC, FL_ZERO, FL_PAST_PREFIX, FL_PAST_PAYLOAD, FL_NOISE} flaw_t;
	typedef enum {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	a2b_in_if  in_ch();
	a2b_out_if out_ch();

	avcc_to_annexb_converter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// converter model state
	logic [2:0]       cfg_len_bytes;
	logic             cfg_long_sc;
	a2b_phase_t       prs_phase;
	logic [LEN_W-1:0] prs_accum;
	logic [2:0]       prs_count;
	logic [LEN_W-1:0] prs_left;
	logic             prs_start;
	a2b_status_t      prs_err;

	conv_beat_t expected_beats[$];
	conv_beat_t head_beat;

	int       errors;
	int       beats_sent;
	int       beats_out;
	int       cfg_writes;
	int       status_seen[4];
	int       burst_left;
	bit       tx_steady;
	rx_mode_t rx_mode;
	logic [7:0] rx_pat;
	int       rx_tick;
	int       hold_left;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [2:0] eff_len();
		if (cfg_len_bytes < LB_MIN)
			return LB_MIN;
		if (cfg_len_bytes > LB_MAX)
			return LB_MAX;
		return cfg_len_bytes;
	endfunction

	function automatic conv_beat_t data_beat(input logic [7:0] b);
		return '{out_byte: b, is_status: 1'b0, status: ST_OK, run_last: 1'b0};
	endfunction

	function automatic void clear_parser();
		prs_phase = PH_PREFIX;
		prs_accum = '0;
		prs_count = '0;
		prs_left  = '0;
		prs_start = 1'b0;
		prs_err   = ST_OK;
	endfunction

	function automatic void predict_conversion(input logic [7:0] b, input logic fe);
		logic [2:0] lb;
		conv_beat_t beats[$];
		lb = eff_len();
		case (prs_phase)
			PH_PREFIX: begin
				prs_accum = {prs_accum[LEN_W-9:0], b};
				prs_count = prs_count + 3'd1;
				if (prs_count >= lb) begin
					if (prs_accum == '0) begin
						prs_err   = ST_ZERO;
						prs_phase = PH_DRAIN;
					end else if (fe) begin
						prs_err   = ST_PAST;
						prs_phase = PH_DRAIN;
					end else begin
						prs_left  = prs_accum;
						prs_start = 1'b1;
						prs_phase = PH_PAYLOAD;
					end
					prs_accum = '0;
					prs_count = '0;
				end else if (fe) begin
					prs_err   = ST_TRUNC;
					prs_phase = PH_DRAIN;
				end
			end
			PH_PAYLOAD: begin
				if (prs_start) begin
					beats.insert(beats.size(), data_beat(8'h00));
					beats.insert(beats.size(), data_beat(8'h00));
					if (cfg_long_sc)
						beats.insert(beats.size(), data_beat(8'h00));
					beats.insert(beats.size(), data_beat(8'h01));
					prs_start = 1'b0;
				end
				beats.insert(beats.size(), data_beat(b));
				prs_left = prs_left - 1;
				if (prs_left == '0) begin
					prs_phase = PH_PREFIX;
				end else if (fe) begin
					prs_err   = ST_PAST;
					prs_phase = PH_DRAIN;
				end
			end
			default: ;
		endcase
		if (fe) begin
			beats.insert(beats.size(),
				'{out_byte: 8'h00, is_status: 1'b1, status: prs_err, run_last: 1'b0});
			clear_parser();
		end
		if (beats.size() > 0)
			beats[beats.size()-1].run_last = 1'b1;
		foreach (beats[i])
			expected_beats.insert(expected_beats.size(), beats[i]);
	endfunction

	task automatic note_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		errors++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_LENGTH_BYTES)
			cfg_len_bytes = val;
		else if (idx == CFG_LONG_SC)
			cfg_long_sc = val[0];
		cfg_writes++;
	endtask

	task automatic send_beat(input logic [7:0] b, input logic fe);
		int gap;
		gap = 0;
		if (!tx_steady) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 15) : $urandom_range(0, 3);
			end
			burst_left--;
		end
		repeat (gap) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
		end
		@(negedge clk);
		in_ch.valid     <= 1'b1;
		in_ch.in_byte   <= b;
		in_ch.frame_end <= fe;
		do
			@(posedge clk);
		while (!in_ch.ready);
		predict_conversion(b, fe);
		beats_sent++;
	endtask

	task automatic send_prefix(input logic [LEN_W-1:0] v, input int nb, input logic fe);
		for (int i = nb - 1; i >= 0; i--)
			send_beat(8'(v >> (8 * i)), fe && (i == 0));
	endtask

	task automatic wait_results();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
	endtask

	// block empty and quiet before a register write
	task automatic wait_idle();
		wait_results();
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic send_frame(input flaw_t flaw, input int n_good, input int max_len);
		int lb;
		int len;
		int k;
		logic [LEN_W-1:0] v;
		lb = int'(eff_len());
		if (flaw == FL_TRUNC && lb < 2)
			flaw = FL_PAST_PAYLOAD;
		if (flaw == FL_NONE && n_good == 0)
			n_good = 1;
		for (int u = 0; u < n_good; u++) begin
			len = $urandom_range(1, max_len);
			send_prefix(len, lb, 1'b0);
			for (int i = 0; i < len; i++)
				send_beat(8'($urandom), flaw == FL_NONE && u == n_good - 1 && i == len - 1);
		end
		case (flaw)
			FL_TRUNC: begin
				k = $urandom_range(1, lb - 1);
				for (int i = 0; i < k; i++)
					send_beat(8'($urandom), i == k - 1);
			end
			FL_ZERO: begin
				k = $urandom_range(0, 5);
				send_prefix('0, lb, k == 0);
				for (int i = 0; i < k; i++)
					send_beat(8'($urandom), i == k - 1);
			end
			FL_PAST_PREFIX: begin
				v = ($urandom_range(0, 3) == 0) ? '1 : LEN_W'($urandom);
				if (lb < 4)
					v = v & ((LEN_W'(1) << (8 * lb)) - 1);
				if (v == '0)
					v = 1;
				send_prefix(v, lb, 1'b1);
			end
			FL_PAST_PAYLOAD: begin
				len = $urandom_range(2, (max_len < 2) ? 2 : max_len);
				send_prefix(len, lb, 1'b0);
				k = $urandom_range(1, len - 1);
				for (int i = 0; i < k; i++)
					send_beat(8'($urandom), i == k - 1);
			end
			FL_NOISE: begin
				k = $urandom_range(1, 15);
				for (int i = 0; i < k; i++)
					send_beat(8'($urandom), (i == k - 1) || ($urandom_range(0, 5) == 0));
			end
			default: ;
		endcase
	endtask

	task automatic test_directed();
		// reset config: 4-byte prefix, long start code
		send_prefix(32'd1, 4, 1'b0);
		send_beat(8'hFF, 1'b1);
		wait_idle();
		write_reg(CFG_LENGTH_BYTES, 3'd1);
		write_reg(CFG_LONG_SC, 3'b110);
		send_prefix(32'd2, 1, 1'b0);
		send_beat(8'h00, 1'b0);
		send_beat(8'h80, 1'b1);
		send_beat(8'h00, 1'b1);
		// zero length, following bytes dropped
		send_beat(8'h00, 1'b0);
		send_beat(8'hAA, 1'b0);
		send_beat(8'h55, 1'b1);
		wait_idle();
		write_reg(CFG_LENGTH_BYTES, 3'd0);
		send_beat(8'hFF, 1'b1);
		wait_idle();
		write_reg(CFG_LENGTH_BYTES, 3'd7);
		send_beat(8'h12, 1'b0);
		send_beat(8'h34, 1'b1);
		send_prefix(32'hFFFF_FFFF, 4, 1'b1);
		wait_idle();
		write_reg(CFG_LENGTH_BYTES, 3'd2);
		write_reg(CFG_LONG_SC, 3'b111);
		send_prefix(32'd3, 2, 1'b0);
		send_beat(8'hAA, 1'b1);
		// prefix length changed part way through a prefix
		send_beat(8'h00, 1'b0);
		wait_idle();
		write_reg(CFG_LENGTH_BYTES, 3'd1);
		send_beat(8'h02, 1'b0);
		send_beat(8'h11, 1'b0);
		send_beat(8'h22, 1'b1);
	endtask

	task automatic test_backpressure();
		wait_idle();
		write_reg(CFG_LENGTH_BYTES, 3'd1);
		write_reg(CFG_LONG_SC, 3'd1);
		tx_steady = 1'b1;
		rx_mode   = RX_OPEN;
		hold_left = 300;
		repeat (8) begin
			send_prefix(32'd1, 1, 1'b0);
			send_beat(8'($urandom), 1'b0);
		end
		send_prefix(32'd2, 1, 1'b0);
		send_beat(8'($urandom), 1'b0);
		send_beat(8'($urandom), 1'b1);
		wait_results();
		tx_steady = 1'b0;
		rx_mode   = RX_PATTERN;
		rx_pat    = 8'($urandom_range(1, 255));
		send_frame(FL_NONE, 4, 6);
		wait_results();
		send_frame(FL_PAST_PAYLOAD, 1, 6);
	endtask

	task automatic test_random_frames();
		int r;
		flaw_t flaw;
		while (beats_sent < ITEMS_TARGET) begin
			wait_idle();
			r = $urandom_range(0, 9);
			write_reg(CFG_LENGTH_BYTES, (r < 2) ? 3'd1 : (r < 4) ? 3'd4 : 3'($urandom_range(0, 7)));
			write_reg(CFG_LONG_SC, 3'($urandom));
			rx_mode   = rx_mode_t'($urandom_range(0, 2));
			rx_pat    = 8'($urandom_range(1, 255));
			tx_steady = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(3, 6)) begin
				r = $urandom_range(0, 19);
				case (r)
					12: flaw = FL_TRUNC;
					13: flaw = FL_ZERO;
					14: flaw = FL_PAST_PREFIX;
					15, 16: flaw = FL_PAST_PAYLOAD;
					17: flaw = FL_NOISE;
					default: flaw = FL_NONE;
				endcase
				send_frame(flaw, (flaw == FL_NONE) ? $urandom_range(1, 3) : $urandom_range(0, 2),
					($urandom_range(0, 9) == 0) ? 40 : 6);
				if ($urandom_range(0, 5) == 0)
					wait_results();
			end
		end
	endtask

	// output side: stalls, plus the long hold-off
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			rx_tick++;
			if (hold_left > 0) begin
				out_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				case (rx_mode)
					RX_OPEN:    out_ch.ready <= 1'b1;
					RX_RANDOM:  out_ch.ready <= ($urandom_range(0, 3) != 0);
					default:    out_ch.ready <= rx_pat[rx_tick % 8];
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			beats_out++;
			if (out_ch.is_status === 1'b1 && !$isunknown(out_ch.frame_status))
				status_seen[out_ch.frame_status]++;
			if (expected_beats.size() == 0) begin
				note_mismatch($sformatf("unexpected beat byte %02h status %0b",
					out_ch.out_byte, out_ch.is_status));
			end else begin
				head_beat = expected_beats.pop_front();
				if (out_ch.out_byte !== head_beat.out_byte)
					note_mismatch($sformatf("out_byte got %02h want %02h",
						out_ch.out_byte, head_beat.out_byte));
				if (out_ch.is_status !== head_beat.is_status)
					note_mismatch($sformatf("is_status got %0b want %0b",
						out_ch.is_status, head_beat.is_status));
				if (out_ch.frame_status !== head_beat.status)
					note_mismatch($sformatf("frame_status got %0d want %0d",
						out_ch.frame_status, head_beat.status));
				if (out_ch.run_last !== head_beat.run_last)
					note_mismatch($sformatf("run_last got %0b want %0b",
						out_ch.run_last, head_beat.run_last));
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[%0t] timeout: no beat moved for %0d cycles, %0d results outstanding",
			$realtime, IDLE_LIMIT, expected_beats.size());
		$display("FAILURE");
		$finish;
	end

	initial begin
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		in_ch.valid     = 1'b0;
		in_ch.in_byte   = '0;
		in_ch.frame_end = 1'b0;
		errors          = 0;
		beats_sent      = 0;
		beats_out       = 0;
		cfg_writes      = 0;
		burst_left      = 0;
		tx_steady       = 1'b0;
		rx_mode         = RX_RANDOM;
		rx_pat          = 8'hB7;
		rx_tick         = 0;
		hold_left       = 0;
		foreach (status_seen[i])
			status_seen[i] = 0;
		cfg_len_bytes = LB_MAX;
		cfg_long_sc   = 1'b1;
		clear_parser();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_backpressure();
		test_random_frames();

		wait_results();
		repeat (SETTLE) @(posedge clk);
		if (expected_beats.size() != 0)
			note_mismatch($sformatf("%0d expected beats never arrived", expected_beats.size()));
		$display("Run covered %0d input bytes, %0d output beats, %0d register writes",
			beats_sent, beats_out, cfg_writes);
		$display("Frame status beats: ok %0d, truncated %0d, zero length %0d, past end %0d",
			status_seen[ST_OK], status_seen[ST_TRUNC], status_seen[ST_ZERO], status_seen[ST_PAST]);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
